@@ design/assert_macros.svh @@
// assertion helper macros for the text edit buffer checker
// no dependencies; take in by include before any use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a named clock and active-low reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same, on the usual clk_i / rst_ni pair
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ design/tsteb_pkg.sv @@
// shared types and constants for the two-stack text edit buffer
// no dependencies
`default_nettype none

package tsteb_pkg;

  localparam int CMD_W  = 3;
  localparam int CHAR_W = 8;
  localparam int CNT_W  = 6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_FWD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_END   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INS   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DISP  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NOP   = 3'd7;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_MOVE_RD,
    OP_MOVE_WR,
    OP_INSERT,
    OP_DELETE,
    OP_DISP_START,
    OP_DISP_RD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   back;   // move direction toward the start
    logic   emit;   // put out the single status transaction
  } ctl_t;

  typedef struct packed {
    logic before_zero;
    logic after_zero;
    logic before_one;
    logic after_one;
    logic total_zero;
    logic disp_end;   // display index is on the last character
  } stat_t;

endpackage

`default_nettype wire

@@ design/tsteb_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tsteb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ design/tsteb_ctrl.sv @@
// command sequencer for the text edit buffer
// depends on tsteb_pkg
`default_nettype none

module tsteb_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  input  wire logic [tsteb_pkg::CMD_W-1:0] cmd_i,
  input  wire tsteb_pkg::stat_t           stat_i,
  output tsteb_pkg::ctl_t                 ctl_o,
  output logic                            busy
);
  import tsteb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;
  localparam logic [1:0] S_DISP = 2'd3;

  logic [1:0] state_q, state_d;
  logic       rep_q, rep_d;
  logic       back_q, back_d;

  always_comb begin
    state_d    = state_q;
    rep_d      = rep_q;
    back_d     = back_q;
    ctl_o.op   = OP_NONE;
    ctl_o.back = back_q;
    ctl_o.emit = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd_i)
            CMD_FWD, CMD_END: begin
              if (stat_i.after_zero) begin
                ctl_o.emit = 1'b1;
              end else begin
                ctl_o.op   = OP_MOVE_RD;
                ctl_o.back = 1'b0;
                back_d     = 1'b0;
                rep_d      = (cmd_i == CMD_END);
                state_d    = S_WR;
              end
            end
            CMD_BACK, CMD_START: begin
              if (stat_i.before_zero) begin
                ctl_o.emit = 1'b1;
              end else begin
                ctl_o.op   = OP_MOVE_RD;
                ctl_o.back = 1'b1;
                back_d     = 1'b1;
                rep_d      = (cmd_i == CMD_START);
                state_d    = S_WR;
              end
            end
            CMD_INS: begin
              ctl_o.op   = OP_INSERT;
              ctl_o.emit = 1'b1;
            end
            CMD_DEL: begin
              ctl_o.op   = OP_DELETE;
              ctl_o.emit = 1'b1;
            end
            CMD_DISP: begin
              if (stat_i.total_zero) begin
                ctl_o.emit = 1'b1;
              end else begin
                ctl_o.op = OP_DISP_START;
                state_d  = S_DISP;
              end
            end
            default: begin
              ctl_o.emit = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        ctl_o.op = OP_MOVE_RD;
        state_d  = S_WR;
      end
      S_WR: begin
        ctl_o.op = OP_MOVE_WR;
        // stop after the last character has crossed the gap
        if (rep_q && !(back_q ? stat_i.before_one : stat_i.after_one)) begin
          state_d = S_RD;
        end else begin
          ctl_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_DISP: begin
        ctl_o.op = OP_DISP_RD;
        if (stat_i.disp_end) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rep_q   <= 1'b0;
      back_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rep_q   <= rep_d;
      back_q  <= back_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ design/tsteb_datapath.sv @@
// counts, text store and result registers of the text edit buffer
// depends on tsteb_pkg and tsteb_ram
`default_nettype none

module tsteb_datapath #(
  parameter int CAPACITY = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tsteb_pkg::ctl_t             ctl_i,
  input  wire logic [tsteb_pkg::CHAR_W-1:0] char_in_i,
  output tsteb_pkg::stat_t                 stat_o,
  output logic                             strobe_o,
  output logic [tsteb_pkg::CHAR_W-1:0]     char_out_o,
  output logic                             char_valid_o,
  output logic                             at_cursor_o,
  output logic [tsteb_pkg::CNT_W-1:0]      text_length_o,
  output logic [tsteb_pkg::CNT_W-1:0]      cursor_pos_o,
  output logic                             overflow_o,
  output logic                             last_o
);
  import tsteb_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [CW-1:0]     before_q, before_d;
  logic [CW-1:0]     after_q, after_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     total, total_d, top_after;
  logic              full;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [CHAR_W-1:0] wdata, rdata;
  logic              disp_rd;

  logic              strobe_q, from_ram_q, at_cur_q, ovf_q, last_q;
  logic [CNT_W-1:0]  len_q, pos_q;

  assign total     = before_q + after_q;
  assign full      = (total >= CAP_C);
  assign top_after = CAP_C - after_q;
  assign disp_rd   = (ctl_i.op == OP_DISP_RD);

  always_comb begin
    before_d = before_q;
    after_d  = after_q;
    idx_d    = idx_q;
    we       = 1'b0;
    waddr    = AW'(before_q);
    wdata    = char_in_i;
    raddr    = AW'(idx_q);
    case (ctl_i.op)
      OP_MOVE_RD: begin
        raddr = ctl_i.back ? AW'(before_q - ONE_C) : AW'(top_after);
      end
      OP_MOVE_WR: begin
        we    = 1'b1;
        wdata = rdata;
        if (ctl_i.back) begin
          waddr    = AW'(top_after - ONE_C);
          before_d = before_q - ONE_C;
          after_d  = after_q + ONE_C;
        end else begin
          waddr    = AW'(before_q);
          before_d = before_q + ONE_C;
          after_d  = after_q - ONE_C;
        end
      end
      OP_INSERT: begin
        if (!full) begin
          we       = 1'b1;
          before_d = before_q + ONE_C;
        end
      end
      OP_DELETE: begin
        if (after_q != '0) begin
          after_d = after_q - ONE_C;
        end
      end
      OP_DISP_START: begin
        idx_d = '0;
      end
      OP_DISP_RD: begin
        // past the cursor the index jumps over the gap
        raddr = (idx_q < before_q) ? AW'(idx_q) : AW'(idx_q + CAP_C - total);
        idx_d = idx_q + ONE_C;
      end
      default: begin
      end
    endcase
  end

  assign total_d = before_d + after_d;

  tsteb_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_q   <= '0;
      after_q    <= '0;
      idx_q      <= '0;
      strobe_q   <= 1'b0;
      from_ram_q <= 1'b0;
      at_cur_q   <= 1'b0;
      ovf_q      <= 1'b0;
      last_q     <= 1'b0;
      len_q      <= '0;
      pos_q      <= '0;
    end else begin
      before_q   <= before_d;
      after_q    <= after_d;
      idx_q      <= idx_d;
      strobe_q   <= ctl_i.emit || disp_rd;
      from_ram_q <= disp_rd;
      at_cur_q   <= disp_rd && (idx_q == before_q);
      ovf_q      <= ctl_i.emit && (ctl_i.op == OP_INSERT) && full;
      last_q     <= ctl_i.emit || (disp_rd && (idx_q == total - ONE_C));
      len_q      <= CNT_W'(total_d);
      pos_q      <= CNT_W'(before_d);
    end
  end

  assign stat_o.before_zero = (before_q == '0);
  assign stat_o.after_zero  = (after_q == '0);
  assign stat_o.before_one  = (before_q == ONE_C);
  assign stat_o.after_one   = (after_q == ONE_C);
  assign stat_o.total_zero  = (total == '0);
  assign stat_o.disp_end    = (idx_q == total - ONE_C);

  assign strobe_o      = strobe_q;
  assign char_out_o    = from_ram_q ? rdata : '0;
  assign char_valid_o  = from_ram_q;
  assign at_cursor_o   = at_cur_q;
  assign text_length_o = len_q;
  assign cursor_pos_o  = pos_q;
  assign overflow_o    = ovf_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

@@ design/two_stack_text_edit_buffer.sv @@
// top level of the two-stack text edit buffer
// depends on tsteb_pkg, tsteb_ctrl, tsteb_datapath (and tsteb_ram below it)
`default_nettype none

// Text edit buffer with an implicit cursor. The text lives in one store of
// CAPACITY bytes as two stacks: characters before the cursor grow up from
// entry 0, characters after it grow down from the top entry. A command is
// taken at a clock edge with start high and busy low. Every command gives
// its results on the result ports, one per cycle, each marked by strobe_o
// for exactly one cycle; the receiver cannot stall, so results must be
// captured when strobe_o is high. Non-display commands give one status
// transaction with char_valid_o low and last_o high. Display gives one
// transaction per character in document order, at_cursor_o on the first
// character after the cursor and last_o on the final one; an empty text
// gives one status transaction. The pacing is set by the single read port
// of the text store: insert, delete, no-op and moves at a boundary show
// their result in the cycle after the command is taken and leave busy low;
// a single forward or back move reads one stack top, then writes it onto
// the other; move to end or start repeats that read and write for each
// character crossing the cursor; display clears its read index, then
// streams one character per cycle, busy held until the last is read. Store
// entries hold no reset value; only reads of live characters are ever used.
module two_stack_text_edit_buffer #(
  parameter int CAPACITY = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // command side
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [tsteb_pkg::CMD_W-1:0]  cmd_i,
  input  wire logic [tsteb_pkg::CHAR_W-1:0] char_in_i,
  // result side
  output logic                             strobe_o,
  output logic [tsteb_pkg::CHAR_W-1:0]     char_out_o,
  output logic                             char_valid_o,
  output logic                             at_cursor_o,
  output logic [tsteb_pkg::CNT_W-1:0]      text_length_o,
  output logic [tsteb_pkg::CNT_W-1:0]      cursor_pos_o,
  output logic                             overflow_o,
  output logic                             last_o
);
  import tsteb_pkg::*;

  // controller to datapath command and status back
  ctl_t  ctl;
  stat_t stat;

  // state machine: decodes commands, repeats single moves for the
  // to-end and to-start walks, and steps the display read index
  tsteb_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .cmd_i (cmd_i),
    .stat_i(stat),
    .ctl_o (ctl),
    .busy  (busy)
  );

  // counts, store and result registers; a move is a read of one stack top
  // followed by a write onto the other stack
  tsteb_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .char_in_i    (char_in_i),
    .stat_o       (stat),
    .strobe_o     (strobe_o),
    .char_out_o   (char_out_o),
    .char_valid_o (char_valid_o),
    .at_cursor_o  (at_cursor_o),
    .text_length_o(text_length_o),
    .cursor_pos_o (cursor_pos_o),
    .overflow_o   (overflow_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

@@ design/tsteb_checker.sv @@
// port-level checks for the text edit buffer, bound to the top level
// depends on tsteb_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module tsteb_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [tsteb_pkg::CMD_W-1:0] cmd_i,
  input wire logic                       strobe_o,
  input wire logic [tsteb_pkg::CHAR_W-1:0] char_out_o,
  input wire logic                       char_valid_o,
  input wire logic                       at_cursor_o,
  input wire logic                       overflow_o,
  input wire logic                       last_o
);
  import tsteb_pkg::*;

  logic status_txn;   // strobed transaction without a character
  logic status_ok;    // closes its command, blank character, no cursor mark
  logic quick_taken;  // insert, delete or no-op command taken at this edge

  assign status_txn  = strobe_o && !char_valid_o;
  assign status_ok   = last_o && (char_out_o == '0) && !at_cursor_o;
  assign quick_taken = start && !busy && (cmd_i inside {CMD_INS, CMD_DEL, CMD_NOP});

  // status transactions always close their command and carry no character
  `ASSERT_STD(a_status_shape, status_txn |-> status_ok, "malformed status transaction")

  // cursor mark only on a displayed character
  `ASSERT_STD(a_cursor_on_char, strobe_o && at_cursor_o |-> char_valid_o, "stray cursor mark")

  // insert, delete and no-op commands answer on the next cycle
  `ASSERT_STD(a_quick_reply, quick_taken |=> status_txn && last_o, "no quick reply")

  // a dropped insert is reported on a status transaction
  `ASSERT_STD(a_overflow_status, strobe_o && overflow_o |-> status_txn && last_o, "bad overflow")

endmodule

bind two_stack_text_edit_buffer tsteb_checker u_checker (.*);

`default_nettype wire

@@ tb/sv/two_stack_text_edit_buffer_tb.sv @@
// self-checking testbench for the two-stack text edit buffer
// depends on tsteb_pkg and two_stack_text_edit_buffer; predicts every result and checks it
`timescale 1ns / 100ps

module two_stack_text_edit_buffer_tb;
  import tsteb_pkg::*;

  localparam int CAP        = 32;
  localparam int STALL_MAX  = 1000;  // quiet cycles before the watchdog gives up
  localparam int DRAIN_WAIT = 8;     // settle time after the last expected result

  // one result transaction as seen on the result ports
  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              char_valid;
    logic              at_cursor;
    logic [CNT_W-1:0]  text_length;
    logic [CNT_W-1:0]  cursor_pos;
    logic              overflow;
    logic              last;
  } edit_result_t;

  // ---------------------------------------------------------------------------
  // scoreboard: keeps its own copy of both stacks and the expected results
  // ---------------------------------------------------------------------------
  class edit_buffer_scoreboard;
    logic [CHAR_W-1:0] text_mem [CAP];
    int                before_n;
    int                after_n;
    edit_result_t      pending_results [$];
    int                error_count;

    // fill in the counts and queue one expected transaction
    function void queue_result(edit_result_t r);
      r.text_length = CNT_W'(before_n + after_n);
      r.cursor_pos  = CNT_W'(before_n);
      pending_results.push_back(r);
    endfunction

    // apply one accepted command to the model and queue what it should produce
    function void note_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch);
      int           total;
      int           k;
      edit_result_t r;
      total = before_n + after_n;
      r = '0;
      r.last = 1'b1;
      case (cmd)
        CMD_FWD: begin
          if (after_n > 0) begin
            text_mem[before_n] = text_mem[CAP - after_n];
            before_n++;
            after_n--;
          end
        end
        CMD_BACK: begin
          if (before_n > 0) begin
            before_n--;
            after_n++;
            text_mem[CAP - after_n] = text_mem[before_n];
          end
        end
        CMD_END: begin
          // destination sits below the source, so copy upward
          for (int i = 0; i < after_n; i++)
            text_mem[before_n + i] = text_mem[CAP - after_n + i];
          before_n += after_n;
          after_n = 0;
        end
        CMD_START: begin
          // destination sits above the source, so copy downward
          for (int i = before_n - 1; i >= 0; i--)
            text_mem[CAP - total + i] = text_mem[i];
          after_n += before_n;
          before_n = 0;
        end
        CMD_INS: begin
          if (total >= CAP) begin
            r.overflow = 1'b1;
          end else begin
            text_mem[before_n] = ch;
            before_n++;
          end
        end
        CMD_DEL: begin
          if (after_n > 0) after_n--;
        end
        CMD_DISP: begin
          if (total > 0) begin
            // one transaction per character, in document order
            k = 0;
            for (int i = 0; i < before_n; i++) begin
              r = '0;
              r.char_out   = text_mem[i];
              r.char_valid = 1'b1;
              r.last       = (k + 1 == total);
              queue_result(r);
              k++;
            end
            for (int i = 0; i < after_n; i++) begin
              r = '0;
              r.char_out   = text_mem[CAP - after_n + i];
              r.char_valid = 1'b1;
              r.at_cursor  = (i == 0);
              r.last       = (k + 1 == total);
              queue_result(r);
              k++;
            end
            return;
          end
        end
        default: ;  // unused code behaves as a no-op
      endcase
      queue_result(r);
    endfunction

    function void report_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        error_count++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name,
                 exp_v, act_v);
      end
    endfunction

    function void check_result(edit_result_t got);
      edit_result_t want;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual %p", $time, got);
        return;
      end
      want = pending_results.pop_front();
      report_field("char_out",    want.char_out,    got.char_out);
      report_field("char_valid",  want.char_valid,  got.char_valid);
      report_field("at_cursor",   want.at_cursor,   got.at_cursor);
      report_field("text_length", want.text_length, got.text_length);
      report_field("cursor_pos",  want.cursor_pos,  got.cursor_pos);
      report_field("overflow",    want.overflow,    got.overflow);
      report_field("last",        want.last,        got.last);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block under test
  // ---------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  cmd_i;
  logic [CHAR_W-1:0] char_in_i;
  logic              strobe_o;
  logic [CHAR_W-1:0] char_out_o;
  logic              char_valid_o;
  logic              at_cursor_o;
  logic [CNT_W-1:0]  text_length_o;
  logic [CNT_W-1:0]  cursor_pos_o;
  logic              overflow_o;
  logic              last_o;

  two_stack_text_edit_buffer #(
    .CAPACITY(CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .char_in_i    (char_in_i),
    .strobe_o     (strobe_o),
    .char_out_o   (char_out_o),
    .char_valid_o (char_valid_o),
    .at_cursor_o  (at_cursor_o),
    .text_length_o(text_length_o),
    .cursor_pos_o (cursor_pos_o),
    .overflow_o   (overflow_o),
    .last_o       (last_o)
  );

  edit_buffer_scoreboard sb;
  bit                    idle_on;  // sender gaps enabled for the current phase
  int                    quiet_cycles;

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // results can't be held off, so grab every strobed transaction at the edge
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o)
      sb.check_result({char_out_o, char_valid_o, at_cursor_o, text_length_o,
                       cursor_pos_o, overflow_o, last_o});
  end

  // watchdog: any accepted command or strobed result counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 sb.pending_results.size());
        $display("two_stack_text_edit_buffer regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------------

  // one command transaction: optional gap, then hold start until busy is low
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      // junk on the command lines while start is low must be ignored
      start     <= 1'b0;
      cmd_i     <= CMD_W'($urandom);
      char_in_i <= CHAR_W'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    cmd_i     <= cmd;
    char_in_i <= ch;
    do @(posedge clk_i); while (busy);
    sb.note_command(cmd, ch);
  endtask

  // random commands; insert and delete weights steer the fill level
  task automatic send_random(int count, int ins_pct, int del_pct);
    int               roll;
    logic [CMD_W-1:0] cmd;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
        cmd = CMD_INS;
      end else if (roll < ins_pct + del_pct) begin
        cmd = CMD_DEL;
      end else begin
        case ($urandom_range(0, 11))
          0, 1, 2:  cmd = CMD_FWD;
          3, 4, 5:  cmd = CMD_BACK;
          6:        cmd = CMD_END;
          7:        cmd = CMD_START;
          8, 9, 10: cmd = CMD_DISP;
          default:  cmd = CMD_NOP;
        endcase
      end
      send_command(cmd, CHAR_W'($urandom));
    end
  endtask

  initial begin
    sb = new;
    sb.before_n = 0;
    sb.after_n  = 0;
    sb.error_count = 0;
    idle_on = 1'b1;
    quiet_cycles = 0;

    rst_ni    <= 1'b0;
    start     <= 1'b0;
    cmd_i     <= CMD_NOP;
    char_in_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: everything at an empty buffer first
    send_command(CMD_DISP,  8'h00);  // empty display gives one status transaction
    send_command(CMD_FWD,   8'h00);  // boundary moves and delete change nothing
    send_command(CMD_BACK,  8'h00);
    send_command(CMD_DEL,   8'h00);
    send_command(CMD_END,   8'h00);
    send_command(CMD_START, 8'h00);
    send_command(CMD_NOP,   8'hff);
    // character extremes and alternating bit patterns
    send_command(CMD_INS,   8'h00);
    send_command(CMD_INS,   8'hff);
    send_command(CMD_INS,   8'ha5);
    send_command(CMD_INS,   8'h5a);
    send_command(CMD_DISP,  8'h00);  // cursor at end: no at_cursor flag
    send_command(CMD_BACK,  8'h00);
    send_command(CMD_DISP,  8'h00);  // cursor before the last character
    send_command(CMD_START, 8'h00);
    send_command(CMD_DISP,  8'h00);  // cursor at start: flag on the first
    send_command(CMD_BACK,  8'h00);  // back at the start boundary
    send_command(CMD_FWD,   8'h00);
    send_command(CMD_DEL,   8'h00);
    send_command(CMD_INS,   8'h81);
    send_command(CMD_END,   8'h00);
    send_command(CMD_FWD,   8'h00);  // forward at the end boundary
    send_command(CMD_DEL,   8'h00);  // delete at end
    send_command(CMD_DISP,  8'h00);

    // fill past capacity so inserts overflow, then look at the full text
    send_random(40, 85, 3);
    send_command(CMD_INS,   8'h7e);
    send_command(CMD_START, 8'h00);
    send_command(CMD_DISP,  8'h00);
    // back-to-back stretch with no sender gaps
    idle_on = 1'b0;
    send_random(15, 35, 15);
    // drain the text with deletes and moves, gaps back on
    idle_on = 1'b1;
    send_command(CMD_START, 8'h00);
    send_random(15, 10, 45);
    send_random(5, 35, 15);
    send_command(CMD_DISP,  8'h00);

    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
      $display("two_stack_text_edit_buffer regression: pass");
    end else begin
      $display("two_stack_text_edit_buffer regression: fail");
    end
    $finish;
  end

endmodule
